// ===== design/abmrd_pkg.sv =====
package abmrd_pkg;

   // default operand width
   localparam int ABMRD_WIDTH = 32;

   // operation select codes
   typedef enum logic [1:0] {
      FUNC_ADD = 2'd0,
      FUNC_SUB = 2'd1,
      FUNC_MUL = 2'd2,
      FUNC_DIV = 2'd3
   } func_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic capture;
   } dp_cmd_type;

endpackage

// ===== design/abmrd_ctrl.sv =====
module abmrd_ctrl
   import abmrd_pkg::*;
#(
   parameter int WIDTH = ABMRD_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
   localparam logic [CW-1:0] LAST_STEP = CW'(WIDTH - 1);

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;
   logic          slot_free;
   logic          iterative;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign iterative = (func_type'(req_func) == FUNC_MUL) || (func_type'(req_func) == FUNC_DIV);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = iterative ? ST_RUN : ST_FINISH;
            end
         end
         ST_RUN: begin
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and commands
   always_comb begin
      req_ready   = 1'b0;
      cmd.load    = 1'b0;
      cmd.step    = 1'b0;
      cmd.capture = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_RUN: begin
            cmd.step = 1'b1;
         end
         ST_FINISH: begin
            cmd.capture = slot_free;
         end
         default: ;
      endcase
   end

   // step counter
   always_comb begin
      if (state_ff == ST_RUN) begin
         cnt_in = cnt_ff + CW'(1);
      end else begin
         cnt_in = '0;
      end
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.capture) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/abmrd_dp.sv =====
module abmrd_dp
   import abmrd_pkg::*;
#(
   parameter int WIDTH = ABMRD_WIDTH
) (
   input  logic             clock,
   input  dp_cmd_type       cmd,
   input  logic [1:0]       req_func,
   input  logic [WIDTH-1:0] req_operand_a,
   input  logic [WIDTH-1:0] req_operand_b,
   output logic [WIDTH-1:0] rsp_result_low,
   output logic [WIDTH-1:0] rsp_result_high,
   output logic             rsp_carry_flag,
   output logic             rsp_overflow_flag,
   output logic             rsp_sign_flag,
   output logic             rsp_zero_flag,
   output logic             rsp_divide_by_zero
);

   // working registers
   func_type         func_ff;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] q_ff, q_in;
   logic [WIDTH-1:0] b_ff;
   logic [WIDTH-1:0] rmask_ff;
   logic             qm1_ff, qm1_in;
   logic             pre_ff;
   logic             addmode_ff;

   // output registers
   logic [WIDTH-1:0] lo_ff, lo_in;
   logic [WIDTH-1:0] hi_ff, hi_in;
   logic             c_ff, c_in;
   logic             v_ff, v_in;
   logic             s_ff, s_in;
   logic             z_ff, z_in;
   logic             dz_ff, dz_in;

   // step datapath signals
   logic [WIDTH-1:0] acc_sh;
   logic [WIDTH-1:0] q_sh;
   logic [WIDTH-1:0] add_x;
   logic [WIDTH-1:0] add_y;
   logic [WIDTH-1:0] add_sum;
   logic             do_sub;
   logic             do_op;
   logic             div_ok;

   // finish signals
   logic [WIDTH-1:0] opb;
   logic [WIDTH:0]   as_sum;
   logic             as_cin;
   logic [WIDTH-1:0] quot;

   // shared add/subtract for one booth or restoring step
   always_comb begin
      acc_sh = {acc_ff[WIDTH-2:0], q_ff[WIDTH-1]};
      q_sh   = {q_ff[WIDTH-2:0], 1'b0};
      if (func_ff == FUNC_MUL) begin
         add_x  = acc_ff;
         do_sub = q_ff[0] && !qm1_ff;
         do_op  = q_ff[0] != qm1_ff;
      end else begin
         add_x  = acc_sh;
         do_sub = !addmode_ff;
         do_op  = 1'b1;
      end
      add_y   = do_sub ? ~b_ff : b_ff;
      add_sum = add_x + add_y + {{(WIDTH-1){1'b0}}, do_sub};
      div_ok  = (add_sum[WIDTH-1] == pre_ff)
                || ((add_sum == '0) && ((q_sh & rmask_ff) == '0));
   end

   // next working state
   always_comb begin
      acc_in = acc_ff;
      q_in   = q_ff;
      qm1_in = qm1_ff;
      if (func_ff == FUNC_MUL) begin
         if (do_op) begin
            acc_in = {add_sum[WIDTH-1], add_sum[WIDTH-1:1]};
            q_in   = {add_sum[0], q_ff[WIDTH-1:1]};
         end else begin
            acc_in = {acc_ff[WIDTH-1], acc_ff[WIDTH-1:1]};
            q_in   = {acc_ff[0], q_ff[WIDTH-1:1]};
         end
         qm1_in = q_ff[0];
      end else begin
         acc_in = div_ok ? add_sum : acc_sh;
         q_in   = {q_sh[WIDTH-1:1], div_ok};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff    <= func_type'(req_func);
         q_ff       <= req_operand_a;
         b_ff       <= req_operand_b;
         acc_ff     <= (func_type'(req_func) == FUNC_DIV) ? {WIDTH{req_operand_a[WIDTH-1]}}
                                                          : '0;
         qm1_ff     <= 1'b0;
         rmask_ff   <= {{(WIDTH-1){1'b1}}, 1'b0};
         pre_ff     <= req_operand_a[WIDTH-1];
         addmode_ff <= req_operand_b[WIDTH-1] != req_operand_a[WIDTH-1];
      end else if (cmd.step) begin
         acc_ff   <= acc_in;
         q_ff     <= q_in;
         qm1_ff   <= qm1_in;
         rmask_ff <= {rmask_ff[WIDTH-2:0], 1'b0};
      end
   end

   // result formation
   always_comb begin
      opb    = (func_ff == FUNC_SUB) ? (~b_ff + {{(WIDTH-1){1'b0}}, 1'b1}) : b_ff;
      as_sum = {1'b0, q_ff} + {1'b0, opb};
      as_cin = as_sum[WIDTH-1] ^ q_ff[WIDTH-1] ^ opb[WIDTH-1];
      quot   = addmode_ff ? (~q_ff + {{(WIDTH-1){1'b0}}, 1'b1}) : q_ff;
      lo_in  = '0;
      hi_in  = '0;
      c_in   = 1'b0;
      v_in   = 1'b0;
      s_in   = 1'b0;
      z_in   = 1'b0;
      dz_in  = 1'b0;
      unique case (func_ff)
         FUNC_ADD, FUNC_SUB: begin
            lo_in = as_sum[WIDTH-1:0];
            c_in  = as_sum[WIDTH];
            v_in  = as_sum[WIDTH] ^ as_cin;
            s_in  = as_sum[WIDTH-1];
            z_in  = as_sum[WIDTH-1:0] == '0;
         end
         FUNC_MUL: begin
            lo_in = q_ff;
            hi_in = acc_ff;
            s_in  = acc_ff[WIDTH-1];
            z_in  = (acc_ff == '0) && (q_ff == '0);
         end
         FUNC_DIV: begin
            if (b_ff == '0) begin
               dz_in = 1'b1;
            end else begin
               lo_in = quot;
               hi_in = acc_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         c_ff  <= c_in;
         v_ff  <= v_in;
         s_ff  <= s_in;
         z_ff  <= z_in;
         dz_ff <= dz_in;
      end
   end

   assign rsp_result_low     = lo_ff;
   assign rsp_result_high    = hi_ff;
   assign rsp_carry_flag     = c_ff;
   assign rsp_overflow_flag  = v_ff;
   assign rsp_sign_flag      = s_ff;
   assign rsp_zero_flag      = z_ff;
   assign rsp_divide_by_zero = dz_ff;

endmodule

// ===== design/alu_booth_multiply_restoring_divide.sv =====
// Signed ALU: add, subtract, Booth radix-2 multiply and restoring divide on
// WIDTH-bit operands, one item at a time. Add and subtract go from acceptance
// straight to the finish state and load the result register there; multiply
// and divide pass through the run state first, where the single shared adder
// performs one Booth or restoring step per cycle. The result sits in an output
// register, so a new item is accepted while the previous result still waits
// to be taken; that item then holds in its last cycle until the output
// register is free.
module alu_booth_multiply_restoring_divide
   import abmrd_pkg::*;
#(
   parameter int WIDTH = ABMRD_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_func,
   input  logic [WIDTH-1:0] req_operand_a,
   input  logic [WIDTH-1:0] req_operand_b,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [WIDTH-1:0] rsp_result_low,
   output logic [WIDTH-1:0] rsp_result_high,
   output logic             rsp_carry_flag,
   output logic             rsp_overflow_flag,
   output logic             rsp_sign_flag,
   output logic             rsp_zero_flag,
   output logic             rsp_divide_by_zero
);

   dp_cmd_type cmd;

   // sequencing
   abmrd_ctrl #(
      .WIDTH(WIDTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func (req_func),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd      (cmd)
   );

   // arithmetic and result registers
   abmrd_dp #(
      .WIDTH(WIDTH)
   ) u_dp (
      .clock             (clock),
      .cmd               (cmd),
      .req_func          (req_func),
      .req_operand_a     (req_operand_a),
      .req_operand_b     (req_operand_b),
      .rsp_result_low    (rsp_result_low),
      .rsp_result_high   (rsp_result_high),
      .rsp_carry_flag    (rsp_carry_flag),
      .rsp_overflow_flag (rsp_overflow_flag),
      .rsp_sign_flag     (rsp_sign_flag),
      .rsp_zero_flag     (rsp_zero_flag),
      .rsp_divide_by_zero(rsp_divide_by_zero)
   );

`ifndef ASSERT_OFF
   // one item in flight: no acceptance right after another
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while previous item still in work");

   // a zero divisor gives zero results
   a_dz_results: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |->
         (rsp_result_low == '0) && (rsp_result_high == '0))
      else $error("nonzero result with zero divisor");

   // a zero divisor gives no other flag
   a_dz_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |->
         !(rsp_carry_flag || rsp_overflow_flag || rsp_sign_flag || rsp_zero_flag))
      else $error("flag raised with zero divisor");
`endif

endmodule
